// File: src/deq_pkg.sv
package deq_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned REQ_W  = 3;
    localparam int unsigned STAT_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_BACK  = 3'd5
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_VALID = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        IDLE      = 1'b0,
        PEEK_WAIT = 1'b1
    } state_t;

endpackage

// File: src/deq_ram.sv
module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/double_ended_queue_unit.sv
// double-ended queue of signed 32-bit words in a ring buffer of DEPTH slots
//
// slave channel: one request per beat. s_tuser carries the request kind
// (push back, push front, pop front, pop back, peek front, peek back),
// s_tdata the word to insert on a push.
// master channel: one beat per peek, and one per push that is dropped
// because the queue is full. m_tuser is the status, m_tdata the peeked word
// (zero unless the status is valid). pops, successful pushes and unused
// request codes produce no beat.
//
// pushes and pops are taken back to back. a peek on a non-empty queue
// issues the slot read, then in the wait state loads the registered read
// data of the simple dual-port storage ram into the output register, which
// drives m_tvalid; no request is taken while the peek waits.
// after reset the queue is empty and no beat is pending; storage needs no
// clearing. a result waits in the output register while the receiver
// stalls; requests that produce no beat are still taken meanwhile, and a
// request that would produce one waits until the register frees.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [WORD_W-1:0] s_tdata,   // push_value
    input  logic [REQ_W-1:0]         s_tuser,   // req_type
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [WORD_W-1:0] m_tdata,   // peek_value
    output logic [STAT_W-1:0]        m_tuser    // status
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    state_t state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic m_valid_reg, m_valid_next;
    logic signed [WORD_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0] m_user_reg, m_user_next;
    logic out_load;

    logic ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    logic [SW-1:0] back_wr_sum, back_rd_sum, front_inc_sum;
    logic [AW-1:0] back_wr_idx, back_rd_idx, front_inc_idx, front_dec_idx;
    logic full, empty, out_free, gives_result;

    always_comb
    begin
        back_wr_sum   = SW'(front_reg) + SW'(count_reg);
        back_rd_sum   = SW'(front_reg) + SW'(count_reg - CW'(1));
        front_inc_sum = SW'(front_reg) + SW'(1);
        if (back_wr_sum >= SW'(DEPTH))
        begin
            back_wr_sum = back_wr_sum - SW'(DEPTH);
        end
        if (back_rd_sum >= SW'(DEPTH))
        begin
            back_rd_sum = back_rd_sum - SW'(DEPTH);
        end
        if (front_inc_sum >= SW'(DEPTH))
        begin
            front_inc_sum = front_inc_sum - SW'(DEPTH);
        end
        back_wr_idx   = back_wr_sum[AW-1:0];
        back_rd_idx   = back_rd_sum[AW-1:0];
        front_inc_idx = front_inc_sum[AW-1:0];
        front_dec_idx = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    end

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        gives_result = 1'b0;
        if (s_tuser inside {REQ_PEEK_FRONT, REQ_PEEK_BACK})
        begin
            gives_result = 1'b1;
        end
        else if (s_tuser inside {REQ_PUSH_BACK, REQ_PUSH_FRONT})
        begin
            gives_result = full;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        out_load     = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = back_wr_idx;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = front_reg;
        s_tready     = 1'b0;

        case (state_reg)
            IDLE:
            begin
                s_tready = out_free || !gives_result;
                if (s_tvalid && s_tready)
                begin
                    case (s_tuser)
                        REQ_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                out_load    = 1'b1;
                                m_user_next = STATUS_FULL;
                                m_data_next = '0;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                out_load    = 1'b1;
                                m_user_next = STATUS_FULL;
                                m_data_next = '0;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = front_dec_idx;
                                front_next  = front_dec_idx;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (!empty)
                            begin
                                front_next = front_inc_idx;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (!empty)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        REQ_PEEK_FRONT, REQ_PEEK_BACK:
                        begin
                            if (empty)
                            begin
                                out_load    = 1'b1;
                                m_user_next = STATUS_EMPTY;
                                m_data_next = '0;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = (s_tuser == REQ_PEEK_BACK) ? back_rd_idx
                                                                         : front_reg;
                                state_next  = PEEK_WAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            PEEK_WAIT:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    m_user_next = STATUS_VALID;
                    m_data_next = ram_rd_data;
                    state_next  = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: src/deq_checker.sv
module deq_checker
    import deq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic signed [WORD_W-1:0] s_tdata,
    input logic [REQ_W-1:0]         s_tuser,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic signed [WORD_W-1:0] m_tdata,
    input logic [STAT_W-1:0]        m_tuser
);

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    // no beat while reset is held
    assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output beat during reset");

    // error statuses carry a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_EMPTY || m_tuser == STATUS_FULL) |-> m_tdata == '0)
        else $error("nonzero word with error status");

    // status stays within its codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_VALID || m_tuser == STATUS_EMPTY
                      || m_tuser == STATUS_FULL))
        else $error("bad status code");

    // a peek taken while the output is idle and drained produces a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid && m_tready
        && (s_tuser == REQ_PEEK_FRONT || s_tuser == REQ_PEEK_BACK)
        |=> ##1 m_tvalid || $past(m_tvalid))
        else $error("peek result missing");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);

// File: test/double_ended_queue_unit_tb.sv
`timescale 1ns / 100ps

module double_ended_queue_unit_tb;
    import deq_pkg::*;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned CLK_HALF    = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RAND_ITEMS  = 1950;
    localparam int unsigned CALM_FROM   = 1650;
    localparam int unsigned HOLD_AT     = 1000;

    // request codes the block ignores
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef enum int unsigned {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } traffic_mode_t;

    typedef struct {
        status_t                  status;
        logic signed [WORD_W-1:0] word;
    } reply_t;

    class deque_scoreboard;
        logic signed [WORD_W-1:0] slots [DEPTH];
        int unsigned              head;
        int unsigned              count;
        int unsigned              fault_count;
        reply_t                   replies_due [$];

        function new();
            head        = 0;
            count       = 0;
            fault_count = 0;
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction

        function void add_reply(status_t status, logic signed [WORD_W-1:0] word);
            reply_t r;
            r.status = status;
            r.word   = word;
            replies_due.insert(replies_due.size(), r);
        endfunction

        // advance the deque state for one accepted request beat
        function void note_request(logic [REQ_W-1:0] kind, logic signed [WORD_W-1:0] word);
            case (kind)
                REQ_PUSH_BACK:
                begin
                    if (count == DEPTH)
                        add_reply(STATUS_FULL, '0);
                    else
                    begin
                        slots[(head + count) % DEPTH] = word;
                        count++;
                    end
                end
                REQ_PUSH_FRONT:
                begin
                    if (count == DEPTH)
                        add_reply(STATUS_FULL, '0);
                    else
                    begin
                        head        = (head + DEPTH - 1) % DEPTH;
                        slots[head] = word;
                        count++;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (count != 0)
                    begin
                        head = (head + 1) % DEPTH;
                        count--;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (count != 0)
                        count--;
                end
                REQ_PEEK_FRONT:
                begin
                    if (count == 0)
                        add_reply(STATUS_EMPTY, '0);
                    else
                        add_reply(STATUS_VALID, slots[head]);
                end
                REQ_PEEK_BACK:
                begin
                    if (count == 0)
                        add_reply(STATUS_EMPTY, '0);
                    else
                        add_reply(STATUS_VALID, slots[(head + count - 1) % DEPTH]);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_reply(logic [STAT_W-1:0] status, logic signed [WORD_W-1:0] word);
            reply_t r;
            if (replies_due.size() == 0)
            begin
                $error("unexpected result beat: status %0d peek_value %0d", status, word);
                fault_count++;
                return;
            end
            r = replies_due[0];
            replies_due.delete(0);
            if (status !== r.status)
            begin
                $error("status: expected %0d, got %0d", r.status, status);
                fault_count++;
            end
            if (word !== r.word)
            begin
                $error("peek_value: expected %0d, got %0d", r.word, word);
                fault_count++;
            end
        endfunction
    endclass

    logic                     clk      = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic signed [WORD_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]         s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic signed [WORD_W-1:0] m_tdata;
    logic [STAT_W-1:0]        m_tuser;

    deque_scoreboard sb = new();

    bit          calm      = 1'b0;
    bit          rx_quiet  = 1'b0;
    int unsigned cycle_cnt = 0;

    double_ended_queue_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever
        begin
            #(CLK_HALF) clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_reply(m_tuser, m_tdata);
        end
    end

    // receiver backpressure
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && !rx_quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic signed [WORD_W-1:0] word);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_replies_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(traffic_mode_t mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                if (r < 35)      return REQ_PUSH_BACK;
                else if (r < 70) return REQ_PUSH_FRONT;
                else if (r < 80) return REQ_PEEK_FRONT;
                else if (r < 90) return REQ_PEEK_BACK;
                else if (r < 95) return REQ_POP_FRONT;
                else             return REQ_POP_BACK;
            end
            MODE_DRAIN:
            begin
                if (r < 33)      return REQ_POP_FRONT;
                else if (r < 65) return REQ_POP_BACK;
                else if (r < 78) return REQ_PEEK_FRONT;
                else if (r < 90) return REQ_PEEK_BACK;
                else if (r < 95) return REQ_PUSH_BACK;
                else             return REQ_PUSH_FRONT;
            end
            default:
                return 3'($urandom_range(REQ_PUSH_BACK, REQ_PEEK_BACK));
        endcase
    endfunction

    initial
    begin
        traffic_mode_t    mode;
        int unsigned      phase_left;
        int unsigned      sent;
        bit               tx_quiet;
        bit               held;
        logic [REQ_W-1:0] kind;

        rst_n      = 1'b0;
        sent       = 0;
        held       = 1'b0;
        tx_quiet   = 1'b0;
        phase_left = 0;
        mode       = MODE_MIX;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corners, ignored codes, extreme words, every request kind
        send_request(REQ_PEEK_FRONT, '0);
        send_request(REQ_PEEK_BACK, -1);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_SPARE_LO, WORD_MAX);
        send_request(REQ_SPARE_HI, WORD_MIN);
        send_request(REQ_PEEK_BACK, '0);
        send_request(REQ_PUSH_BACK, WORD_MAX);
        send_request(REQ_PUSH_FRONT, WORD_MIN);
        send_request(REQ_PEEK_FRONT, '0);
        send_request(REQ_PEEK_BACK, '0);
        send_request(REQ_PUSH_BACK, '0);
        send_request(REQ_PUSH_FRONT, -1);
        send_request(REQ_PEEK_FRONT, '0);
        send_request(REQ_PEEK_BACK, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_PEEK_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_PEEK_BACK, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_PEEK_FRONT, '0);
        send_request(REQ_PEEK_BACK, '0);
        wait_replies_drained();

        while (sent < RAND_ITEMS)
        begin
            if (phase_left == 0)
            begin
                mode       = traffic_mode_t'($urandom_range(MODE_FILL, MODE_MIX));
                phase_left = $urandom_range(20, 120);
                tx_quiet   = ($urandom_range(0, 3) == 0);
                rx_quiet   = ($urandom_range(0, 3) == 0);
            end
            if (sent >= CALM_FROM)
                calm = 1'b1;
            if (!held && sent >= HOLD_AT)
            begin
                held = 1'b1;
                wait_replies_drained();
            end

            // stray codes mixed in as noise
            if ($urandom_range(0, 99) < 3)
                kind = ($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
            else
            begin
                kind = pick_request(mode);
                sent++;
                phase_left--;
            end
            send_request(kind, pick_word());

            if (!calm && !tx_quiet && $urandom_range(0, 6) == 0)
                sender_gap($urandom_range(1, 8));
        end

        wait_replies_drained();
        repeat (8) @(posedge clk);
        if (sb.fault_count == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
